// ----- rtl/ascending_combination_enumerator_assert.svh -----
// assertion macros for the ascending combination enumerator
// no dependencies; included by the top level only
`ifndef ASCENDING_COMBINATION_ENUMERATOR_ASSERT_SVH
`define ASCENDING_COMBINATION_ENUMERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define ACE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ace assertion failed");
`define ACE_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("ace forbidden condition");
`else
`define ACE_ASSERT(lbl, clk, rstn, prop)
`define ACE_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- rtl/acomb_pkg.sv -----
// shared constants and cell control types of the ascending combination enumerator
// no dependencies
package acomb_pkg;

  localparam int NumElems = 8;
  localparam int ValueW   = 14;
  localparam int PickW    = 4;
  localparam int ReqW     = 2;
  localparam int StatW    = 2;

  localparam logic [ReqW-1:0] ReqClear = 2'd0;
  localparam logic [ReqW-1:0] ReqLoad  = 2'd1;
  localparam logic [ReqW-1:0] ReqNext  = 2'd2;

  localparam logic [StatW-1:0] StatOk   = 2'd0;
  localparam logic [StatW-1:0] StatFull = 2'd1;
  localparam logic [StatW-1:0] StatDup  = 2'd2;
  localparam logic [StatW-1:0] StatExh  = 2'd3;

  localparam logic [PickW-1:0] PickReset = 4'd1;

  typedef struct packed {
    logic wr;
    logic occ;
  } val_ctl_t;

  typedef struct packed {
    logic upd;
    logic active;
  } pick_ctl_t;

endpackage

// ----- rtl/acomb_val_cell.sv -----
// one slot of the sorted value chain: compares against the load value and shifts right
// depends on acomb_pkg
module acomb_val_cell (
  input  logic                          clk_i,
  input  acomb_pkg::val_ctl_t           ctl_i,
  input  logic [acomb_pkg::ValueW-1:0]  value_i,
  input  logic [acomb_pkg::ValueW-1:0]  left_val_i,
  input  logic                          left_gt_i,
  output logic [acomb_pkg::ValueW-1:0]  val_o,
  output logic                          gt_o,
  output logic                          eq_o
);
  import acomb_pkg::*;

  logic [ValueW-1:0] val_q, val_d;

  assign gt_o = ctl_i.occ && (val_q > value_i);
  assign eq_o = ctl_i.occ && (val_q == value_i);
  assign val_o = val_q;

  always_comb begin
    if (left_gt_i) begin
      val_d = left_val_i;
    end else if (gt_o || !ctl_i.occ) begin
      val_d = value_i;
    end else begin
      val_d = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      val_q <= val_d;
    end
  end

endmodule

// ----- rtl/acomb_pick_cell.sv -----
// one position of the pick index chain: finds the rightmost movable index and refills the tail
// depends on acomb_pkg
module acomb_pick_cell #(
  parameter int IW = 3,
  parameter int LW = 7
) (
  input  logic                  clk_i,
  input  acomb_pkg::pick_ctl_t  ctl_i,
  input  logic [LW-1:0]         lim_i,
  input  logic                  found_i,
  input  logic                  after_i,
  input  logic [IW-1:0]         left_nxt_i,
  output logic                  found_o,
  output logic                  after_o,
  output logic [IW-1:0]         nxt_o,
  output logic [IW-1:0]         idx_o
);
  import acomb_pkg::*;

  logic [IW-1:0] idx_q;
  logic          movable;
  logic          sel;

  assign movable = ctl_i.active && (LW'(idx_q) < lim_i);
  assign sel     = movable && !found_i;
  assign found_o = found_i || movable;
  assign after_o = after_i || sel;
  assign idx_o   = idx_q;

  always_comb begin
    if (after_i) begin
      nxt_o = left_nxt_i + IW'(1);
    end else if (sel) begin
      nxt_o = idx_q + IW'(1);
    end else begin
      nxt_o = idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd) begin
      idx_q <= nxt_o;
    end
  end

endmodule

// ----- rtl/ascending_combination_enumerator.sv -----
// ascending combination enumerator: sorted value set and lexicographic k-combination stepping
// input channel: req_type_i/value_i beats on in_valid_i, held off by in_stall_o. a clear (0)
//   empties the set, a load (1) inserts value_i in sorted order, a next (2) steps the enumeration.
// output channel: one beat per request on out_valid_o, held by out_stall_i. elem_0..7 carry
//   the combination (0 beyond pick_count), combo_valid_o, last_combo_o and status_o.
// config: cfg_we_i writes cfg_wdata_i into pick_count and restarts the enumeration; write
//   only while no request is in flight.
// pipeline: the first stage updates the value chain and the pick index chain on an accepted
//   request, the next reads the chosen values into the output register for the result beat.
// throughput: one request per cycle while the output is not stalled.
// when out_stall_i holds a result, one more request is taken into the read stage, then
//   in_stall_o rises until the output register drains.
// reset: set empty, pick_count 1, enumeration restarted, both stages empty.
`include "ascending_combination_enumerator_assert.svh"
module ascending_combination_enumerator #(
  parameter int MAX_SET = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [acomb_pkg::PickW-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [acomb_pkg::ReqW-1:0]         req_type_i,
  input  logic [acomb_pkg::ValueW-1:0]       value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [acomb_pkg::ValueW-1:0]       elem_0_o,
  output logic [acomb_pkg::ValueW-1:0]       elem_1_o,
  output logic [acomb_pkg::ValueW-1:0]       elem_2_o,
  output logic [acomb_pkg::ValueW-1:0]       elem_3_o,
  output logic [acomb_pkg::ValueW-1:0]       elem_4_o,
  output logic [acomb_pkg::ValueW-1:0]       elem_5_o,
  output logic [acomb_pkg::ValueW-1:0]       elem_6_o,
  output logic [acomb_pkg::ValueW-1:0]       elem_7_o,
  output logic                               combo_valid_o,
  output logic                               last_combo_o,
  output logic [acomb_pkg::StatW-1:0]        status_o
);
  import acomb_pkg::*;

  localparam int CW   = $clog2(MAX_SET + 1);
  localparam int IW   = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
  localparam int LW   = CW + 3;
  localparam int CmpW = (CW > PickW) ? CW : PickW;

  logic [PickW-1:0] k_q;
  logic [CW-1:0]    n_q, n_d;
  logic             started_q, started_d;
  logic             exh_q, exh_d;

  logic             p_valid_q, p_valid_d;
  logic             p_combo_q, p_last_q;
  logic [StatW-1:0] p_stat_q;
  logic             p_move;

  logic             out_valid_q;
  logic [ValueW-1:0] out_elem_q [NumElems];
  logic [ValueW-1:0] elem_d [NumElems];
  logic             out_combo_q, out_last_q;
  logic [StatW-1:0] out_stat_q;

  logic             take;
  logic             ins_en, pick_upd;
  logic             combo_d, last_d;
  logic [StatW-1:0] stat_d;
  logic             dup, full, bad, last_hit;
  logic [LW-1:0]    nk;

  logic [ValueW-1:0] val_w [MAX_SET];
  logic [MAX_SET-1:0] gt_w, eq_w;
  logic [ValueW-1:0] lval_w [MAX_SET];
  logic [MAX_SET-1:0] lgt_w;

  logic [NumElems:0]  found_w, after_w;
  logic [IW-1:0]      nxt_w [NumElems];
  logic [IW-1:0]      lnxt_w [NumElems];
  logic [IW-1:0]      idx_w [NumElems];

  // handshake
  assign p_move     = p_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = p_valid_q && !p_move;
  assign take       = in_valid_i && !in_stall_o;
  assign p_valid_d  = take || (p_valid_q && !p_move);

  // value chain
  genvar gi;
  generate
    for (gi = 0; gi < MAX_SET; gi++) begin : g_val
      val_ctl_t vctl;
      if (gi == 0) begin : g_head
        assign lval_w[gi] = '0;
        assign lgt_w[gi]  = 1'b0;
      end else begin : g_link
        assign lval_w[gi] = val_w[gi-1];
        assign lgt_w[gi]  = gt_w[gi-1];
      end
      assign vctl.wr  = ins_en;
      assign vctl.occ = CW'(gi) < n_q;
      acomb_val_cell u_cell (
        .clk_i      (clk_i),
        .ctl_i      (vctl),
        .value_i    (value_i),
        .left_val_i (lval_w[gi]),
        .left_gt_i  (lgt_w[gi]),
        .val_o      (val_w[gi]),
        .gt_o       (gt_w[gi]),
        .eq_o       (eq_w[gi])
      );
    end
  endgenerate

  assign dup  = |eq_w;
  assign full = (n_q == CW'(MAX_SET));

  // pick index chain
  assign nk           = LW'(n_q) - LW'(k_q);
  assign found_w[NumElems] = 1'b0;
  assign after_w[0]   = !started_q;

  generate
    for (gi = 0; gi < NumElems; gi++) begin : g_pick
      pick_ctl_t pctl;
      if (gi == 0) begin : g_head
        assign lnxt_w[gi] = '1;
      end else begin : g_link
        assign lnxt_w[gi] = nxt_w[gi-1];
      end
      assign pctl.upd    = pick_upd;
      assign pctl.active = PickW'(gi) < k_q;
      acomb_pick_cell #(
        .IW (IW),
        .LW (LW)
      ) u_cell (
        .clk_i      (clk_i),
        .ctl_i      (pctl),
        .lim_i      (nk + LW'(gi)),
        .found_i    (found_w[gi+1]),
        .after_i    (after_w[gi]),
        .left_nxt_i (lnxt_w[gi]),
        .found_o    (found_w[gi]),
        .after_o    (after_w[gi+1]),
        .nxt_o      (nxt_w[gi]),
        .idx_o      (idx_w[gi])
      );
    end
  endgenerate

  assign bad = (k_q == '0) || (k_q > PickW'(NumElems)) || (CmpW'(k_q) > CmpW'(n_q)) || exh_q;
  assign last_hit = (LW'(nxt_w[0]) == nk);

  // request decode
  always_comb begin
    n_d       = n_q;
    started_d = started_q;
    exh_d     = exh_q;
    ins_en    = 1'b0;
    pick_upd  = 1'b0;
    combo_d   = 1'b0;
    last_d    = 1'b0;
    stat_d    = StatOk;
    if (take) begin
      case (req_type_i)
        ReqClear: begin
          n_d       = '0;
          started_d = 1'b0;
          exh_d     = 1'b0;
        end
        ReqLoad: begin
          if (dup) begin
            stat_d = StatDup;
          end else if (full) begin
            stat_d = StatFull;
          end else begin
            ins_en    = 1'b1;
            n_d       = n_q + CW'(1);
            started_d = 1'b0;
            exh_d     = 1'b0;
          end
        end
        ReqNext: begin
          if (bad) begin
            stat_d = StatExh;
          end else if (!started_q || found_w[0]) begin
            pick_upd  = 1'b1;
            started_d = 1'b1;
            combo_d   = 1'b1;
            last_d    = last_hit;
            exh_d     = last_hit;
          end else begin
            exh_d  = 1'b1;
            stat_d = StatExh;
          end
        end
        default: begin
          stat_d = StatOk;
        end
      endcase
    end
  end

  // read stage
  always_comb begin
    for (int i = 0; i < NumElems; i++) begin
      if (p_combo_q && (PickW'(i) < k_q)) begin
        elem_d[i] = val_w[idx_w[i]];
      end else begin
        elem_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= PickReset;
      n_q         <= '0;
      started_q   <= 1'b0;
      exh_q       <= 1'b0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
      if (p_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        k_q       <= cfg_wdata_i;
        started_q <= 1'b0;
        exh_q     <= 1'b0;
      end else begin
        n_q       <= n_d;
        started_q <= started_d;
        exh_q     <= exh_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      p_combo_q <= combo_d;
      p_last_q  <= last_d;
      p_stat_q  <= stat_d;
    end
    if (p_move) begin
      out_elem_q  <= elem_d;
      out_combo_q <= p_combo_q;
      out_last_q  <= p_last_q;
      out_stat_q  <= p_stat_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign elem_0_o      = out_elem_q[0];
  assign elem_1_o      = out_elem_q[1];
  assign elem_2_o      = out_elem_q[2];
  assign elem_3_o      = out_elem_q[3];
  assign elem_4_o      = out_elem_q[4];
  assign elem_5_o      = out_elem_q[5];
  assign elem_6_o      = out_elem_q[6];
  assign elem_7_o      = out_elem_q[7];
  assign combo_valid_o = out_combo_q;
  assign last_combo_o  = out_last_q;
  assign status_o      = out_stat_q;

  `ACE_ASSERT_NEVER(a_size_bound, clk_i, rst_ni, n_q > CW'(MAX_SET))
  `ACE_ASSERT_NEVER(a_exh_needs_start, clk_i, rst_ni, exh_q && !started_q)
  `ACE_ASSERT(a_no_combo_zero, clk_i, rst_ni, (out_valid_o && !combo_valid_o) |-> ((elem_0_o == '0) && (elem_7_o == '0) && !last_combo_o))
  `ACE_ASSERT(a_last_is_combo, clk_i, rst_ni, (p_move && p_last_q) |=> (combo_valid_o && (status_o == StatOk)))

endmodule

// ----- bench/ascending_combination_enumerator_test.sv -----
`timescale 1ns / 1ps
// self-checking bench for ascending_combination_enumerator: a directed table, then random
// clear/load/next sequences over several pick_count settings, checked against a local predictor
// depends on acomb_pkg and the enumerator rtl
module ascending_combination_enumerator_test;
  import acomb_pkg::*;

  localparam logic [ReqW-1:0] ReqSpare = 2'd3;
  localparam int HoldCycles = 60;
  localparam int PhaseItems = 80;
  localparam int NumPhases = 10;
  localparam logic [NumPhases-1:0][PickW-1:0] PickPlan =
    {4'd7, 4'd6, 4'd15, 4'd5, 4'd0, 4'd4, 4'd1, 4'd3, 4'd2, 4'd8};

  typedef struct packed {
    logic [NumElems-1:0][ValueW-1:0] elem;
    logic                            combo_valid;
    logic                            last_combo;
    logic [StatW-1:0]                status;
  } combo_beat_t;

  typedef struct packed {
    logic [ReqW-1:0]   req;
    logic [ValueW-1:0] value;
    logic              pinned;
    combo_beat_t       want;
  } stim_row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [PickW-1:0]                cfg_wdata_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [ReqW-1:0]                 req_type_i;
  logic [ValueW-1:0]               value_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [NumElems-1:0][ValueW-1:0] elems_seen;
  logic                            combo_valid_o;
  logic                            last_combo_o;
  logic [StatW-1:0]                status_o;

  // tags that travel with the input beat
  logic        in_pinned;
  combo_beat_t in_want;

  int          idle_pct;
  int          stall_pct;
  bit          hold_req;
  int          errors;
  combo_beat_t pending_beats[$];

  // predictor state
  logic [ValueW-1:0] set_vals [NumElems];
  int unsigned       set_count;
  int unsigned       pick_idx [NumElems];
  bit                enum_started;
  bit                enum_done;
  logic [PickW-1:0]  pick_k;

  ascending_combination_enumerator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .elem_0_o     (elems_seen[0]),
    .elem_1_o     (elems_seen[1]),
    .elem_2_o     (elems_seen[2]),
    .elem_3_o     (elems_seen[3]),
    .elem_4_o     (elems_seen[4]),
    .elem_5_o     (elems_seen[5]),
    .elem_6_o     (elems_seen[6]),
    .elem_7_o     (elems_seen[7]),
    .combo_valid_o(combo_valid_o),
    .last_combo_o (last_combo_o),
    .status_o     (status_o)
  );

  function automatic void rewind_combos();
    for (int i = 0; i < NumElems; i++) pick_idx[i] = 0;
    enum_started = 1'b0;
    enum_done = 1'b0;
  endfunction

  function automatic combo_beat_t beat_of(logic [ValueW-1:0] first, logic valid, logic last,
                                          logic [StatW-1:0] stat);
    combo_beat_t b;
    b = '0;
    b.elem[0] = first;
    b.combo_valid = valid;
    b.last_combo = last;
    b.status = stat;
    return b;
  endfunction

  function automatic combo_beat_t predict_beat(logic [ReqW-1:0] req, logic [ValueW-1:0] val);
    combo_beat_t r;
    int unsigned pos;
    int unsigned k;
    int unsigned j;
    bit found;
    r = '0;
    r.status = StatOk;
    case (req)
      ReqClear: begin
        set_count = 0;
        rewind_combos();
      end
      ReqLoad: begin
        pos = 0;
        for (int i = 0; i < set_count; i++) begin
          if (set_vals[i] == val) r.status = StatDup;
          else if (set_vals[i] < val) pos = i + 1;
        end
        if (r.status != StatDup) begin
          if (set_count >= NumElems) begin
            r.status = StatFull;
          end else begin
            for (int i = set_count; i > pos; i--) set_vals[i] = set_vals[i-1];
            set_vals[pos] = val;
            set_count++;
            rewind_combos();
          end
        end
      end
      ReqNext: begin
        k = pick_k;
        if (k == 0 || k > NumElems || k > set_count || enum_done) begin
          r.status = StatExh;
        end else begin
          found = 1'b1;
          if (!enum_started) begin
            for (int i = 0; i < k; i++) pick_idx[i] = i;
            enum_started = 1'b1;
          end else begin
            // rightmost index that can still move right
            found = 1'b0;
            j = k;
            while (j > 0 && !found) begin
              j--;
              if (pick_idx[j] < set_count - k + j) found = 1'b1;
            end
            if (!found) begin
              enum_done = 1'b1;
              r.status = StatExh;
            end else begin
              pick_idx[j]++;
              for (int i = j + 1; i < k; i++) pick_idx[i] = pick_idx[i-1] + 1;
            end
          end
          if (found) begin
            for (int i = 0; i < k; i++) r.elem[i] = set_vals[pick_idx[i]];
            r.combo_valid = 1'b1;
            if (pick_idx[0] == set_count - k) begin
              r.last_combo = 1'b1;
              enum_done = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk_i) begin : scoreboard
    combo_beat_t seen;
    combo_beat_t exp_beat;
    combo_beat_t calc;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.elem = elems_seen;
        seen.combo_valid = combo_valid_o;
        seen.last_combo = last_combo_o;
        seen.status = status_o;
        if (pending_beats.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, expected none, got status %0d",
                   $time, status_o);
        end else begin
          exp_beat = pending_beats.pop_front();
          for (int i = 0; i < NumElems; i++) begin
            if (seen.elem[i] !== exp_beat.elem[i]) begin
              errors++;
              $display("%0t: elem_%0d expected %0d got %0d", $time, i, exp_beat.elem[i],
                       seen.elem[i]);
            end
          end
          if (seen.combo_valid !== exp_beat.combo_valid) begin
            errors++;
            $display("%0t: combo_valid expected %0b got %0b", $time, exp_beat.combo_valid,
                     seen.combo_valid);
          end
          if (seen.last_combo !== exp_beat.last_combo) begin
            errors++;
            $display("%0t: last_combo expected %0b got %0b", $time, exp_beat.last_combo,
                     seen.last_combo);
          end
          if (seen.status !== exp_beat.status) begin
            errors++;
            $display("%0t: status expected %0d got %0d", $time, exp_beat.status, seen.status);
          end
        end
      end
      if (cfg_we_i) begin
        pick_k = cfg_wdata_i;
        rewind_combos();
      end
      if (in_valid_i && !in_stall_o) begin
        calc = predict_beat(req_type_i, value_i);
        pending_beats.push_back(in_pinned ? in_want : calc);
      end
    end
  end

  // receiver side
  initial begin : receiver
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_beat(logic [ReqW-1:0] req, logic [ValueW-1:0] val, logic pinned,
                           combo_beat_t want);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      req_type_i <= ReqW'($urandom);
      value_i <= ValueW'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    value_i <= val;
    in_pinned <= pinned;
    in_want <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin : stimulus
    stim_row_t   dir_rows[$];
    int unsigned n_loads;
    int unsigned n_nexts;
    int unsigned n_set;
    int unsigned k;
    int unsigned combos;
    int unsigned made;
    bit          narrow;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = PickReset;
    in_valid_i = 1'b0;
    req_type_i = ReqClear;
    value_i = '0;
    in_pinned = 1'b0;
    in_want = '0;
    idle_pct = 31;
    stall_pct = 31;
    hold_req = 1'b0;
    errors = 0;
    pick_k = PickReset;
    set_count = 0;
    for (int i = 0; i < NumElems; i++) set_vals[i] = '0;
    rewind_combos();

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // pick_count 1 after reset
    dir_rows.push_back('{ReqNext, 14'd0, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatExh)});
    dir_rows.push_back('{ReqSpare, 14'd16383, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatOk)});
    dir_rows.push_back('{ReqLoad, 14'd0, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatOk)});
    dir_rows.push_back('{ReqLoad, 14'd0, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatDup)});
    dir_rows.push_back('{ReqLoad, 14'd16383, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatOk)});
    dir_rows.push_back('{ReqNext, 14'd16383, 1'b1, beat_of(14'd0, 1'b1, 1'b0, StatOk)});
    dir_rows.push_back('{ReqNext, 14'd0, 1'b1, beat_of(14'd16383, 1'b1, 1'b1, StatOk)});
    dir_rows.push_back('{ReqNext, 14'd0, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatExh)});
    dir_rows.push_back('{ReqLoad, 14'd10922, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatOk)});
    dir_rows.push_back('{ReqLoad, 14'd5461, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatOk)});
    dir_rows.push_back('{ReqLoad, 14'd100, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatOk)});
    dir_rows.push_back('{ReqLoad, 14'd7, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatOk)});
    dir_rows.push_back('{ReqLoad, 14'd9000, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatOk)});
    dir_rows.push_back('{ReqLoad, 14'd12000, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatOk)});
    // set now full; duplicate wins over full
    dir_rows.push_back('{ReqLoad, 14'd3000, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatFull)});
    dir_rows.push_back('{ReqLoad, 14'd7, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatDup)});
    dir_rows.push_back('{ReqNext, 14'd0, 1'b1, beat_of(14'd0, 1'b1, 1'b0, StatOk)});
    dir_rows.push_back('{ReqNext, 14'd0, 1'b0, combo_beat_t'('0)});
    dir_rows.push_back('{ReqNext, 14'd0, 1'b0, combo_beat_t'('0)});
    dir_rows.push_back('{ReqClear, 14'd16383, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatOk)});
    dir_rows.push_back('{ReqNext, 14'd0, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatExh)});
    dir_rows.push_back('{ReqLoad, 14'd42, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatOk)});
    dir_rows.push_back('{ReqNext, 14'd0, 1'b1, beat_of(14'd42, 1'b1, 1'b1, StatOk)});
    dir_rows.push_back('{ReqNext, 14'd0, 1'b1, beat_of(14'd0, 1'b0, 1'b0, StatExh)});

    foreach (dir_rows[r]) begin
      send_beat(dir_rows[r].req, dir_rows[r].value, dir_rows[r].pinned, dir_rows[r].want);
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain_pipeline();
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= PickPlan[p];
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      idle_pct = (p == 2 || p == 4) ? 0 : 31;
      stall_pct = (p == 2) ? 0 : 31;
      // long receiver hold-off while the sender keeps offering
      if (p == 4) hold_req = 1'b1;
      k = PickPlan[p];
      made = 0;
      while (made < PhaseItems) begin
        if ($urandom_range(0, 9) == 0) begin
          send_beat(ReqW'($urandom), ValueW'($urandom), 1'b0, '0);
          made++;
        end else begin
          send_beat(ReqClear, ValueW'($urandom), 1'b0, '0);
          n_loads = $urandom_range(0, 10);
          narrow = ($urandom_range(0, 3) == 0);
          for (int i = 0; i < n_loads; i++) begin
            send_beat(ReqLoad, narrow ? ValueW'($urandom_range(0, 11)) : ValueW'($urandom),
                      1'b0, '0);
          end
          n_set = (n_loads > NumElems) ? NumElems : n_loads;
          combos = 0;
          if (k >= 1 && k <= n_set) begin
            combos = 1;
            for (int i = 0; i < k; i++) combos = combos * (n_set - i) / (i + 1);
          end
          n_nexts = combos + $urandom_range(0, 2);
          if (n_nexts > 75) n_nexts = 75;
          if (n_nexts > 0 && $urandom_range(0, 3) == 0) n_nexts = $urandom_range(1, n_nexts);
          for (int i = 0; i < n_nexts; i++) begin
            send_beat(ReqNext, ValueW'($urandom), 1'b0, '0);
          end
          made += 1 + n_loads + n_nexts;
        end
      end
    end

    drain_pipeline();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
